// File: src/bcc_pkg.sv
// Shared types and constants for the button click classifier.
package bcc_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned ThreshW = 16;
  localparam int unsigned CountW = 8;
  localparam int unsigned AddrW  = 4;
  localparam int unsigned DataW  = 32;

  localparam logic [1:0] FUNC_POLL    = 2'd0;
  localparam logic [1:0] FUNC_PRESS   = 2'd1;
  localparam logic [1:0] FUNC_RELEASE = 2'd2;

  localparam logic [1:0] REG_DEBOUNCE     = 2'd0;
  localparam logic [1:0] REG_LONG_PRESS   = 2'd1;
  localparam logic [1:0] REG_DOUBLE_CLICK = 2'd2;

  localparam logic [ThreshW-1:0] DEBOUNCE_RST     = 16'd50;
  localparam logic [ThreshW-1:0] LONG_PRESS_RST   = 16'd1000;
  localparam logic [ThreshW-1:0] DOUBLE_CLICK_RST = 16'd300;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SINGLE = 2'd1,
    EV_DOUBLE = 2'd2,
    EV_LONG   = 2'd3
  } event_t;

endpackage

// File: src/button_click_classifier.sv
// Button click classifier: press, release and poll beats to click events.
// Each beat passes an input register and then a result register.
// Throughput: one beat per cycle while m_tready does not stall the result register.
// Backpressure on m_tready stalls the result register and also the input register while that holds a beat.
// Reset clears the stamps, click count and pending event, reloads the thresholds
// (50, 1000, 300) and empties both registers.
module button_click_classifier (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [bcc_pkg::TimeW-1:0] s_tdata,   // [31:0] time_ms
  input  logic [1:0]               s_tuser,   // [1:0] func
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [7:0]               m_tdata,   // [1:0] event_out, [7:2] zero
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [bcc_pkg::AddrW-1:0] paddr,
  input  logic [bcc_pkg::DataW-1:0] pwdata,
  output logic [bcc_pkg::DataW-1:0] prdata,
  output logic                     pready
);
  import bcc_pkg::*;

  logic [ThreshW-1:0] debounce_ms;
  logic [ThreshW-1:0] long_press_ms;
  logic [ThreshW-1:0] double_click_ms;

  logic [TimeW-1:0]  press_stamp, press_stamp_next;
  logic [TimeW-1:0]  release_stamp, release_stamp_next;
  logic [TimeW-1:0]  prior_release_stamp, prior_release_stamp_next;
  logic [CountW-1:0] clicks_seen, clicks_seen_next;
  event_t            pending_event, pending_event_next;

  logic             in_valid;
  logic [1:0]       in_func;
  logic [TimeW-1:0] in_time;
  event_t           out_event, out_event_next;

  logic out_ready;
  logic proc;
  logic cfg_wr;

  logic [TimeW-1:0] held;
  logic [TimeW-1:0] gap;
  logic [TimeW-1:0] since_press;
  logic [TimeW-1:0] deb_w, long_w, dcm_w;
  logic             is_double, is_single;

  assign pready    = 1'b1;
  assign cfg_wr    = psel & penable & pwrite & pready;
  assign out_ready = ~m_tvalid | m_tready;
  assign s_tready  = ~in_valid | out_ready;
  assign proc      = in_valid & out_ready;
  assign m_tdata   = {6'd0, out_event};

  always_comb begin
    unique case (paddr[3:2])
      REG_DEBOUNCE:     prdata = {{(DataW-ThreshW){1'b0}}, debounce_ms};
      REG_LONG_PRESS:   prdata = {{(DataW-ThreshW){1'b0}}, long_press_ms};
      REG_DOUBLE_CLICK: prdata = {{(DataW-ThreshW){1'b0}}, double_click_ms};
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms     <= DEBOUNCE_RST;
      long_press_ms   <= LONG_PRESS_RST;
      double_click_ms <= DOUBLE_CLICK_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_DEBOUNCE:     debounce_ms     <= pwdata[ThreshW-1:0];
        REG_LONG_PRESS:   long_press_ms   <= pwdata[ThreshW-1:0];
        REG_DOUBLE_CLICK: double_click_ms <= pwdata[ThreshW-1:0];
        default: ;
      endcase
    end
  end

  assign deb_w       = {{(TimeW-ThreshW){1'b0}}, debounce_ms};
  assign long_w      = {{(TimeW-ThreshW){1'b0}}, long_press_ms};
  assign dcm_w       = {{(TimeW-ThreshW){1'b0}}, double_click_ms};
  assign held        = in_time - press_stamp;
  assign gap         = press_stamp - prior_release_stamp;
  assign since_press = in_time - press_stamp;
  assign is_double   = (clicks_seen == CountW'(2)) && (gap > deb_w) && (gap <= dcm_w);
  assign is_single   = (clicks_seen == CountW'(1)) && (since_press > dcm_w);

  always_comb begin
    press_stamp_next         = press_stamp;
    release_stamp_next       = release_stamp;
    prior_release_stamp_next = prior_release_stamp;
    clicks_seen_next         = clicks_seen;
    pending_event_next       = pending_event;
    out_event_next           = EV_NONE;
    case (in_func)
      FUNC_POLL: begin
        if (is_double) begin
          out_event_next   = EV_DOUBLE;
          clicks_seen_next = '0;
        end else if (is_single) begin
          out_event_next   = EV_SINGLE;
          clicks_seen_next = '0;
        end else begin
          out_event_next = pending_event;
        end
        pending_event_next = EV_NONE;
      end
      FUNC_PRESS: begin
        press_stamp_next = in_time;
      end
      FUNC_RELEASE: begin
        if (held > deb_w) begin
          if (held >= long_w) begin
            pending_event_next = EV_LONG;
            clicks_seen_next   = '0;
          end else begin
            clicks_seen_next         = clicks_seen + CountW'(1);
            prior_release_stamp_next = release_stamp;
            release_stamp_next       = in_time;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid            <= 1'b0;
      m_tvalid            <= 1'b0;
      press_stamp         <= '0;
      release_stamp       <= '0;
      prior_release_stamp <= '0;
      clicks_seen         <= '0;
      pending_event       <= EV_NONE;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (out_ready) begin
        m_tvalid <= in_valid;
      end
      if (proc) begin
        press_stamp         <= press_stamp_next;
        release_stamp       <= release_stamp_next;
        prior_release_stamp <= prior_release_stamp_next;
        clicks_seen         <= clicks_seen_next;
        pending_event       <= pending_event_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_func <= s_tuser;
      in_time <= s_tdata;
    end
    if (proc) begin
      out_event <= out_event_next;
    end
  end

`ifndef SYNTHESIS
  a_poll_clears_pending: assert property (@(posedge clk) disable iff (rst)
    (proc && in_func == FUNC_POLL) |=> pending_event == EV_NONE)
    else $error("pending event survived a poll");

  a_edge_no_event: assert property (@(posedge clk) disable iff (rst)
    (proc && in_func != FUNC_POLL) |=> (m_tvalid && out_event == EV_NONE))
    else $error("edge beat produced an event");

  a_ready_follows_out: assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready)
    else $error("input stalled while output ready");

  a_long_clears_clicks: assert property (@(posedge clk) disable iff (rst)
    (proc && in_func == FUNC_RELEASE && held > deb_w && held >= long_w)
      |=> (clicks_seen == '0 && pending_event == EV_LONG))
    else $error("long press did not clear the click count");
`endif

endmodule

// File: dv/button_click_classifier_tb.sv
// Testbench for the button click classifier: directed, wrap and random beats vs. a predictor.
module button_click_classifier_tb;
  import bcc_pkg::*;

  localparam logic [1:0] FuncUnused = 2'd3;
  localparam logic [1:0] RegSpare = 2'd3;
  localparam int unsigned StallLimit = 2000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [TimeW-1:0] s_tdata = '0;
  logic [1:0] s_tuser = FUNC_POLL;
  logic m_tvalid;
  logic m_tready = 1'b1;
  logic [7:0] m_tdata;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic pready;

  button_click_classifier dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Classifier state mirror
  logic [TimeW-1:0] press_at = '0;
  logic [TimeW-1:0] release_at = '0;
  logic [TimeW-1:0] prior_release_at = '0;
  logic [CountW-1:0] click_count = '0;
  event_t pending = EV_NONE;
  logic [ThreshW-1:0] bounce_lim = DEBOUNCE_RST;
  logic [ThreshW-1:0] long_lim = LONG_PRESS_RST;
  logic [ThreshW-1:0] window_lim = DOUBLE_CLICK_RST;

  event_t expected_events[$];
  bit tx_idle = 1'b1;
  bit rx_stall = 1'b1;
  int unsigned fail_count = 0;
  int unsigned beats_sent = 0;
  int unsigned results_seen = 0;
  int unsigned phases = 0;
  int unsigned stalled_cycles = 0;
  logic [TimeW-1:0] clock_ms = '0;

  function automatic event_t classify(input logic [1:0] func, input logic [TimeW-1:0] now);
    logic [TimeW-1:0] held;
    logic [TimeW-1:0] gap;
    event_t ev;
    ev = EV_NONE;
    held = now - press_at;
    gap = press_at - prior_release_at;
    case (func)
      FUNC_POLL: begin
        if (click_count == 8'd2 && gap > 32'(bounce_lim) && gap <= 32'(window_lim)) begin
          pending = EV_DOUBLE;
          click_count = '0;
        end else if (click_count == 8'd1 && held > 32'(window_lim)) begin
          pending = EV_SINGLE;
          click_count = '0;
        end
        ev = pending;
        pending = EV_NONE;
      end
      FUNC_PRESS: press_at = now;
      FUNC_RELEASE: begin
        if (held > 32'(bounce_lim)) begin
          if (held >= 32'(long_lim)) begin
            pending = EV_LONG;
            click_count = '0;
          end else begin
            click_count = click_count + 8'd1;
            prior_release_at = release_at;
            release_at = now;
          end
        end
      end
      default: ;
    endcase
    return ev;
  endfunction

  function automatic logic [TimeW-1:0] near_threshold();
    case ($urandom_range(0, 7))
      0: return 32'(bounce_lim);
      1: return 32'(bounce_lim) + 32'd1;
      2: return 32'(long_lim) - 32'd1;
      3: return 32'(long_lim);
      4: return 32'(window_lim);
      5: return 32'(window_lim) + 32'd1;
      6: return 32'($urandom_range(0, 2000));
      default: return $urandom();
    endcase
  endfunction

  task automatic send_beat(input logic [1:0] func, input logic [TimeW-1:0] now);
    if (tx_idle && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= func;
    s_tdata <= now;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_events.push_back(classify(func, now));
    beats_sent++;
    @(negedge clk);
  endtask

  // Hold off until every expected result beat has come back
  task automatic drain();
    s_tvalid <= 1'b0;
    while (expected_events.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [ThreshW-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'($urandom()), value};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_DEBOUNCE: bounce_lim = value;
      REG_LONG_PRESS: long_lim = value;
      REG_DOUBLE_CLICK: window_lim = value;
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_session();
    if ($urandom_range(0, 9) == 0) begin
      send_beat(2'($urandom_range(0, 3)), $urandom());
    end else begin
      if ($urandom_range(0, 7) == 0) clock_ms = $urandom();
      repeat ($urandom_range(1, 3)) begin
        send_beat(FUNC_PRESS, clock_ms);
        clock_ms += near_threshold();
        if ($urandom_range(0, 9) != 0) send_beat(FUNC_RELEASE, clock_ms);
        clock_ms += near_threshold();
      end
      repeat ($urandom_range(1, 3)) begin
        send_beat(FUNC_POLL, clock_ms);
        clock_ms += near_threshold();
      end
    end
  endtask

  task automatic run_phase(input logic [ThreshW-1:0] b, l, w, input int unsigned beats);
    int unsigned stop_at;
    drain();
    write_reg(REG_DEBOUNCE, b);
    write_reg(REG_LONG_PRESS, l);
    write_reg(REG_DOUBLE_CLICK, w);
    if ($urandom_range(0, 1) == 1) write_reg(RegSpare, 16'($urandom()));
    phases++;
    stop_at = beats_sent + beats;
    while (beats_sent < stop_at) random_session();
  endtask

  // Reset thresholds: bounce, click, double, long, single timeout, three clicks with no event, unused selector, wrap
  task automatic test_directed();
    send_beat(FUNC_POLL, 32'd0);
    send_beat(FuncUnused, 32'hFFFF_FFFF);
    send_beat(FUNC_PRESS, 32'd1000);
    send_beat(FUNC_RELEASE, 32'd1050);
    send_beat(FUNC_RELEASE, 32'd1051);
    send_beat(FUNC_PRESS, 32'd1200);
    send_beat(FUNC_RELEASE, 32'd1300);
    send_beat(FUNC_POLL, 32'd1310);
    send_beat(FUNC_PRESS, 32'd6000);
    send_beat(FUNC_RELEASE, 32'd7000);
    send_beat(FUNC_POLL, 32'd7001);
    send_beat(FUNC_PRESS, 32'd8000);
    send_beat(FUNC_RELEASE, 32'd8100);
    send_beat(FUNC_POLL, 32'd8300);
    send_beat(FUNC_POLL, 32'd8301);
    send_beat(FUNC_PRESS, 32'd9000);
    send_beat(FUNC_RELEASE, 32'd9100);
    send_beat(FUNC_PRESS, 32'd9200);
    send_beat(FUNC_RELEASE, 32'd9300);
    send_beat(FUNC_PRESS, 32'd9400);
    send_beat(FUNC_RELEASE, 32'd9500);
    send_beat(FUNC_POLL, 32'd20000);
    send_beat(FUNC_PRESS, 32'hFFFF_FF00);
    send_beat(FUNC_RELEASE, 32'h0000_0300);
    send_beat(FUNC_POLL, 32'h0000_0400);
    drain();
  endtask

  // Push the click count past 255 with short clicks, then let a single click time out
  task automatic test_click_wrap();
    clock_ms = $urandom();
    repeat (257) begin
      send_beat(FUNC_PRESS, clock_ms);
      clock_ms += 32'($urandom_range(51, 999));
      send_beat(FUNC_RELEASE, clock_ms);
      clock_ms += 32'($urandom_range(51, 400));
    end
    send_beat(FUNC_POLL, clock_ms + 32'd1000);
    drain();
  endtask

  task automatic test_random();
    run_phase(DEBOUNCE_RST, LONG_PRESS_RST, DOUBLE_CLICK_RST, 36);
    run_phase(16'd0, 16'd0, 16'd0, 36);
    run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 36);
    run_phase(16'd1000, 16'd50, 16'd300, 36);
    run_phase(16'd0, 16'hFFFF, 16'hFFFF, 36);
    run_phase(16'($urandom()), 16'($urandom()), 16'($urandom()), 36);
    drain();
    tx_idle = 1'b0;
    rx_stall = 1'b0;
    run_phase(16'd20, 16'd400, 16'd150, 36);
  endtask

  always begin
    @(negedge clk);
    if (rx_stall && $urandom_range(0, 4) == 0) begin
      m_tready <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    m_tready <= 1'b1;
  end

  always @(posedge clk) begin : check_results
    event_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (expected_events.size() == 0) begin
        $error("result beat with no expectation pending: event_out=%0d", m_tdata[1:0]);
        fail_count++;
      end else begin
        want = expected_events.pop_front();
        if (m_tdata[1:0] !== want) begin
          $error("event_out mismatch: expected %0d, actual %0d", want, m_tdata[1:0]);
          fail_count++;
        end
        if (m_tdata[7:2] !== 6'd0) begin
          $error("m_tdata pad mismatch: expected 0, actual %0d", m_tdata[7:2]);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stalled_cycles <= 0;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
    if (stalled_cycles >= StallLimit) begin
      $display("watchdog: no beat accepted for %0d cycles", stalled_cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_click_wrap();
    test_random();
    drain();
    $display("Sent %0d beats: directed edges and polls, click-count wrap, random sessions",
             beats_sent);
    $display("over %0d threshold settings; %0d result beats checked", phases, results_seen);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
